// ===== rtl/fcgi_pkg.sv =====
// Shared types and constants for the FastCGI record deframer.
// No dependencies; every other file of the block imports this package.
package fcgi_pkg;

    // Header layout
    localparam logic [2:0] HDR_IDX_TYPE   = 3'd1;
    localparam logic [2:0] HDR_IDX_LEN_HI = 3'd4;
    localparam logic [2:0] HDR_IDX_LEN_LO = 3'd5;
    localparam logic [2:0] HDR_IDX_PAD    = 3'd6;
    localparam logic [2:0] HDR_IDX_LAST   = 3'd7;

    // Record types
    localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
    localparam logic [7:0] TYPE_STDOUT      = 8'd6;
    localparam logic [7:0] TYPE_STDERR      = 8'd7;

    // Result channel codes
    localparam logic [1:0] CH_STDOUT = 2'd0;
    localparam logic [1:0] CH_STDERR = 2'd1;
    localparam logic [1:0] CH_END    = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] channel;
    } t_result;

endpackage

// ===== rtl/fcgi_front.sv =====
// Front end: accepts stream bytes, collects record headers, tracks the body
// and classifies each byte into zero or one tagged result. Uses fcgi_pkg.
module fcgi_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_stream_byte,
    output logic              o_res_valid,
    output fcgi_pkg::t_result o_res
);
    import fcgi_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_idx, n_hdr_idx;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_content, n_content;
    logic [7:0]  r_padding, n_padding;
    logic [16:0] r_consumed, n_consumed;

    logic [16:0] total;
    logic [16:0] consumed_inc;
    logic        hdr_done;
    logic        is_content;
    logic        body_last;
    logic        is_text;

    // Decode the current record
    assign total        = {1'b0, r_content} + {9'd0, r_padding};
    assign consumed_inc = r_consumed + 17'd1;
    assign hdr_done     = (r_hdr_idx == HDR_IDX_LAST);
    assign is_content   = (r_consumed < {1'b0, r_content});
    assign body_last    = (consumed_inc >= total);
    assign is_text      = (r_type == TYPE_STDOUT) || (r_type == TYPE_STDERR);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEADER: begin
                if (i_accept && hdr_done) begin
                    if (r_type == TYPE_END_REQUEST) begin
                        n_phase = PH_DONE;
                    end else if (total == 17'd0) begin
                        n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (i_accept && body_last) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
    end

    // Result for the byte being accepted
    always_comb begin
        o_res_valid        = 1'b0;
        o_res.payload_byte = i_stream_byte;
        o_res.channel      = CH_STDOUT;
        unique case (r_phase)
            PH_HEADER: begin
                o_res_valid        = i_accept && hdr_done && (r_type == TYPE_END_REQUEST);
                o_res.payload_byte = 8'd0;
                o_res.channel      = CH_END;
            end
            PH_BODY: begin
                o_res_valid   = i_accept && is_content && is_text;
                o_res.channel = (r_type == TYPE_STDOUT) ? CH_STDOUT : CH_STDERR;
            end
            PH_DONE: o_res_valid = 1'b0;
            default: o_res_valid = 1'b0;
        endcase
    end

    // Header capture and body count
    always_comb begin
        n_hdr_idx  = r_hdr_idx;
        n_type     = r_type;
        n_content  = r_content;
        n_padding  = r_padding;
        n_consumed = r_consumed;
        if (i_accept && (r_phase == PH_HEADER)) begin
            case (r_hdr_idx)
                HDR_IDX_TYPE:   n_type = i_stream_byte;
                HDR_IDX_LEN_HI: n_content = {i_stream_byte, r_content[7:0]};
                HDR_IDX_LEN_LO: n_content = {r_content[15:8], i_stream_byte};
                HDR_IDX_PAD:    n_padding = i_stream_byte;
                default:        n_type = r_type;
            endcase
            n_hdr_idx = r_hdr_idx + 3'd1;
            if (hdr_done) begin
                n_consumed = 17'd0;
            end
        end else if (i_accept && (r_phase == PH_BODY)) begin
            if (body_last) begin
                n_consumed = 17'd0;
                n_hdr_idx  = 3'd0;
            end else begin
                n_consumed = consumed_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= 3'd0;
            r_type     <= 8'd0;
            r_content  <= 16'd0;
            r_padding  <= 8'd0;
            r_consumed <= 17'd0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_type     <= n_type;
            r_content  <= n_content;
            r_padding  <= n_padding;
            r_consumed <= n_consumed;
        end
    end

endmodule

// ===== rtl/fcgi_queue.sv =====
// Short result queue between the front end and the output stage.
// Register-array FIFO with a fill count. Uses fcgi_pkg for the entry type.
module fcgi_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  fcgi_pkg::t_result i_wr_data,
    input  logic              i_rd,
    output fcgi_pkg::t_result o_rd_data,
    output logic              o_full,
    output logic              o_empty
);
    import fcgi_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_wr;
    logic          do_rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/fcgi_back.sv =====
// Output stage: pulls results from the queue into a register and presents
// them on the result ports until popped. Uses fcgi_pkg for the entry type.
module fcgi_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  fcgi_pkg::t_result i_q_data,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output fcgi_pkg::t_result o_res
);
    import fcgi_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // Refill when the register is free or being popped
    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_q_rd) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_res <= i_q_data;
        end
    end

endmodule

// ===== rtl/fastcgi_record_deframer.sv =====
// FastCGI record deframer, top level.
// Splits a server byte stream into records and passes stdout and stderr
// content out tagged with its channel.
//
// Input channel: push i_stream_byte while o_full is low; one byte is taken
// per cycle at full rate. Header bytes, padding and bodies of other record
// types are consumed without a result.
// Result channel: while o_empty is low, o_payload_byte and o_channel show
// the oldest result; raise i_pop to take it. Channel 0 is stdout, 1 is
// stderr, 2 marks the end-request header (payload zero), after which all
// further bytes are consumed silently until reset.
// A result is written into the queue, then moved to the output register
// that drives the ports. Throughput: one byte per cycle while o_full is
// low, set by the header capture and body count compare in the front end.
// When the receiver stalls, results collect in a QUEUE_DEPTH-entry queue
// plus the output register; o_full rises once the queue fills.
// Reset (synchronous, active low) returns to header collection and drops
// every queued result.
module fastcgi_record_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_stream_byte,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_payload_byte,
    output logic [1:0] o_channel
);
    import fcgi_pkg::*;

    logic    accept;
    logic    fr_valid;
    t_result fr_res;
    logic    q_full;
    logic    q_empty;
    logic    q_rd;
    t_result q_data;
    t_result out_res;

    assign o_full = q_full;
    assign accept = i_push && !q_full;

    fcgi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_stream_byte (i_stream_byte),
        .o_res_valid   (fr_valid),
        .o_res         (fr_res)
    );

    fcgi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (fr_valid),
        .i_wr_data (fr_res),
        .i_rd      (q_rd),
        .o_rd_data (q_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    fcgi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (out_res)
    );

    assign o_payload_byte = out_res.payload_byte;
    assign o_channel      = out_res.channel;

endmodule

// ===== rtl/fcgi_chk.sv =====
// Port-level checker for the FastCGI record deframer, bound to the top.
// Uses fcgi_pkg for channel codes.
module fcgi_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_full,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_payload_byte,
    input logic [1:0] o_channel
);
    import fcgi_pkg::*;

    // Reset drops every waiting result and frees the input
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty && !o_full)
        else $error("outputs not cleared by reset");

    // Only defined channel codes leave the block
    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_channel == CH_STDOUT || o_channel == CH_STDERR ||
                      o_channel == CH_END))
        else $error("undefined channel code");

    // End result carries a zero payload
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_channel == CH_END) |-> (o_payload_byte == 8'd0))
        else $error("end result with nonzero payload");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_payload_byte) &&
                                  $stable(o_channel)))
        else $error("stalled result changed");

endmodule

bind fastcgi_record_deframer fcgi_chk u_chk (.*);

// ===== test/fastcgi_record_deframer_checker.sv =====
// Checker for the FastCGI record deframer: watches the input and result channels,
// predicts each result from the accepted stream bytes and compares in order.
// Depends on fcgi_pkg for the record types, channel codes and result layout.
`timescale 1ns / 1ps

module fastcgi_record_deframer_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_stream_byte,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_payload_byte,
    input  logic [1:0] i_channel,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count
);
    import fcgi_pkg::*;

    // Predicted deframer state
    t_phase      phase;
    logic [2:0]  hdr_pos;
    logic [7:0]  rec_type;
    logic [15:0] content_len;
    logic [7:0]  pad_len;
    logic [16:0] body_count;

    // Channel outputs predicted but not yet popped, oldest first
    t_result expected_output_q[$];

    task automatic report_mismatch(input string what, input string expected_txt,
                                   input string actual_txt);
        o_fail_count++;
        $display("%0t ns: %s mismatch, expected %s, actual %s",
                 $time, what, expected_txt, actual_txt);
    endtask

    // Advance the predicted state by one stream byte; queue any output it makes
    task automatic deframe_byte(input logic [7:0] b);
        logic [16:0] total;
        t_result     res;
        case (phase)
            PH_HEADER: begin
                case (hdr_pos)
                    HDR_IDX_TYPE:   rec_type = b;
                    HDR_IDX_LEN_HI: content_len[15:8] = b;
                    HDR_IDX_LEN_LO: content_len[7:0] = b;
                    HDR_IDX_PAD:    pad_len = b;
                    default: ;
                endcase
                if (hdr_pos != HDR_IDX_LAST) begin
                    hdr_pos = hdr_pos + 3'd1;
                end else begin
                    hdr_pos = '0;
                    body_count = '0;
                    total = {1'b0, content_len} + {9'd0, pad_len};
                    if (rec_type == TYPE_END_REQUEST) begin
                        // end request wins over whatever the lengths say
                        phase = PH_DONE;
                        res.payload_byte = '0;
                        res.channel = CH_END;
                        expected_output_q.push_back(res);
                    end else if (total == '0) begin
                        phase = PH_HEADER;
                    end else begin
                        phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                total = {1'b0, content_len} + {9'd0, pad_len};
                if (body_count < {1'b0, content_len} &&
                    (rec_type == TYPE_STDOUT || rec_type == TYPE_STDERR)) begin
                    res.payload_byte = b;
                    res.channel = (rec_type == TYPE_STDOUT) ? CH_STDOUT : CH_STDERR;
                    expected_output_q.push_back(res);
                end
                body_count = body_count + 17'd1;
                if (body_count >= total) begin
                    phase = PH_HEADER;
                    hdr_pos = '0;
                    body_count = '0;
                end
            end
            default: ;  // finished: drop every byte
        endcase
    endtask

    // Compare popped results first, then predict from the accepted byte
    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            phase = PH_HEADER;
            hdr_pos = '0;
            rec_type = '0;
            content_len = '0;
            pad_len = '0;
            body_count = '0;
            expected_output_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                o_result_count++;
                if (expected_output_q.size() == 0) begin
                    report_mismatch("unexpected result", "none",
                                    $sformatf("byte %02h channel %0d",
                                              i_payload_byte, i_channel));
                end else begin
                    exp_res = expected_output_q.pop_front();
                    if (i_payload_byte !== exp_res.payload_byte) begin
                        report_mismatch("payload byte",
                                        $sformatf("%02h", exp_res.payload_byte),
                                        $sformatf("%02h", i_payload_byte));
                    end
                    if (i_channel !== exp_res.channel) begin
                        report_mismatch("channel",
                                        $sformatf("%0d", exp_res.channel),
                                        $sformatf("%0d", i_channel));
                    end
                end
            end
            if (i_push && !i_full) begin
                deframe_byte(i_stream_byte);
            end
        end
        o_pending = expected_output_q.size();
    end

endmodule

// ===== test/fastcgi_record_deframer_test.sv =====
// Top of the FastCGI record deframer testbench: clock, reset, byte stream
// stimulus, result popping and the verdict. Depends on fcgi_pkg, the block
// and fastcgi_record_deframer_checker, which does all prediction and compare.
`timescale 1ns / 1ps

module fastcgi_record_deframer_test;
    import fcgi_pkg::*;

    localparam int RANDOM_BYTES = 1600;
    localparam int BIG_CONTENT  = 300;
    localparam int BIG_PADDING  = 255;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    // ~1.7k bytes, each at worst the longest send gap plus the longest pop gap
    localparam int CYCLE_LIMIT  = 400_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] stream_byte;
    logic       empty;
    logic       pop;
    logic [7:0] payload_byte;
    logic [1:0] channel;

    int fail_count;
    int pending;
    int result_count;
    int bytes_sent;
    int full_stall_cycles;
    bit hold_request;
    bit hold_done;
    bit sender_calm;
    bit receiver_calm;

    fastcgi_record_deframer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_stream_byte  (stream_byte),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_payload_byte (payload_byte),
        .o_channel      (channel)
    );

    fastcgi_record_deframer_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_stream_byte  (stream_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_payload_byte (payload_byte),
        .i_channel      (channel),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic logic [7:0] pick_other_type();
        logic [7:0] t;
        do begin
            t = 8'($urandom_range(0, 255));
        end while (t == TYPE_END_REQUEST || t == TYPE_STDOUT || t == TYPE_STDERR);
        return t;
    endfunction

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) begin
                stream_byte <= 8'($urandom_range(0, 255));
                @(posedge i_clk);
            end
        end
        push <= 1'b1;
        stream_byte <= b;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] rtype, input logic [15:0] clen,
                               input logic [7:0] plen);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(rtype);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(clen[15:8]);
        send_byte(clen[7:0]);
        send_byte(plen);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_body(input int n);
        for (int k = 0; k < n; k++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly short stdout/stderr records, some dropped types, rare long lengths
    task automatic send_random_record();
        int         sel;
        logic [7:0] rtype;
        int         clen;
        int         plen;
        sel = $urandom_range(0, 9);
        if (sel < 4) rtype = TYPE_STDOUT;
        else if (sel < 7) rtype = TYPE_STDERR;
        else rtype = pick_other_type();
        sel = $urandom_range(0, 19);
        if (sel < 2) clen = 0;
        else if (sel == 2) clen = $urandom_range(256, 520);
        else clen = $urandom_range(1, 12);
        sel = $urandom_range(0, 19);
        if (sel < 12) plen = 0;
        else if (sel < 19) plen = $urandom_range(1, 7);
        else plen = $urandom_range(248, 255);
        sender_calm = ($urandom_range(0, 3) == 0);
        send_header(rtype, clen[15:0], plen[7:0]);
        send_body(clen + plen);
    endtask

    // Stream source and verdict
    initial begin
        int start_count;
        int big_bytes;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        stream_byte <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty record, then stdout with padding, then stderr
        send_header(TYPE_STDOUT, 16'd0, 8'd0);
        send_header(TYPE_STDOUT, 16'd2, 8'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_header(TYPE_STDERR, 16'd1, 8'd0);
        send_byte(8'h80);

        start_count = bytes_sent;
        big_bytes = 0;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            if (big_bytes == 0 && bytes_sent - start_count >= RANDOM_BYTES / 2) begin
                // long padded record; the receiver holds off meanwhile
                big_bytes = bytes_sent;
                sender_calm = 1'b0;
                send_header(TYPE_STDOUT, BIG_CONTENT[15:0], BIG_PADDING[7:0]);
                hold_request = 1'b1;
                send_body(BIG_CONTENT + BIG_PADDING);
                big_bytes = bytes_sent - big_bytes;
                // pause until every predicted output has been popped
                push <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end else begin
                send_random_record();
            end
        end

        // end request with nonzero lengths, then bytes that must be dropped
        sender_calm = 1'b0;
        send_header(TYPE_END_REQUEST, 16'h1234, 8'h05);
        send_header(TYPE_STDOUT, 16'd4, 8'd0);
        send_body($urandom_range(12, 34));
        push <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d bytes incl. one long padded record; %0d results checked.",
                 bytes_sent, result_count);
        $display("Input held off by a full queue for %0d cycles; stream ended on end request.",
                 full_stall_cycles);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result sink: random pop gaps, calm stretches and one long hold-off
    initial begin
        int gap;
        int pops;
        pops = 0;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            gap = pick_gap(receiver_calm);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            pops++;
            if (pops % 64 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
        end
    end

    // Count cycles where the block refuses an offered byte
    always @(posedge i_clk) begin
        if (i_rst_n && push && full) full_stall_cycles++;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 CYCLE_LIMIT, pending);
        $display("FAIL");
        $finish;
    end

endmodule
